// ===== src/fp32_fp16_converter_defines.svh =====
// Assertion macros for the fp32/fp16 converter.
`ifndef FP32_FP16_CONVERTER_DEFINES_SVH
`define FP32_FP16_CONVERTER_DEFINES_SVH
// Check that an antecedent implies a consequent on the next clock.
`define FCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Check that a condition holds at every clock.
`define FCV_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

// ===== src/fcv_pkg.sv =====
// Package with conversion functions for the fp32/fp16 converter.
`default_nettype none
package fcv_pkg;
  typedef enum logic {
    MODE_NARROW = 1'b0,
    MODE_WIDEN  = 1'b1
  } fcv_mode_e;

  function automatic logic [15:0] fcv_narrow(input logic [31:0] w);
    logic [15:0] sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [15:0] mag;
    logic [12:0] rem;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [23:0] rm;
    logic [23:0] half;
    logic [23:0] msk;
    sgn  = {w[31], 15'd0};
    e    = w[30:23];
    m    = w[22:0];
    mag  = '0;
    rem  = '0;
    sig  = {1'b1, m};
    sh   = 5'(8'd126 - e);
    q    = sig >> sh;
    msk  = (24'd1 << sh) - 24'd1;
    rm   = sig & msk;
    half = 24'd1 << (sh - 5'd1);
    if (e == 8'hFF) begin
      fcv_narrow = sgn | ((m != '0) ? 16'h7E00 : 16'h7C00);
    end else if (e >= 8'd143) begin
      fcv_narrow = sgn | 16'h7C00;
    end else if (e == 8'd0) begin
      fcv_narrow = sgn;
    end else if (e >= 8'd113) begin
      mag = {1'b0, 5'(e - 8'd112), m[22:13]};
      rem = m[12:0];
      if (rem > 13'h1000 || (rem == 13'h1000 && mag[0])) begin
        mag = mag + 16'd1;
      end
      fcv_narrow = sgn | mag;
    end else if (e < 8'd102) begin
      fcv_narrow = sgn;
    end else begin
      if (rm > half || (rm == half && q[0])) begin
        q = q + 24'd1;
      end
      fcv_narrow = sgn | q[15:0];
    end
  endfunction

  function automatic logic [31:0] fcv_widen(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  k;
    logic [10:0] mn;
    sgn = {h[15], 31'd0};
    e   = h[14:10];
    m   = h[9:0];
    k   = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (m[i] && k == 4'd0) begin
        k = 4'(10 - i);
      end
    end
    mn = 11'({1'b0, m} << k);
    if (e == 5'h1F) begin
      fcv_widen = sgn | 32'h7F800000 | {9'd0, m, 13'd0} |
                  ((m != '0) ? 32'h00400000 : 32'd0);
    end else if (e == 5'd0) begin
      if (m == '0) begin
        fcv_widen = sgn;
      end else begin
        fcv_widen = sgn | {1'b0, 8'(8'd113 - {4'd0, k}), mn[9:0], 13'd0};
      end
    end else begin
      fcv_widen = sgn | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
  endfunction
endpackage
`default_nettype wire

// ===== src/fcv_core.sv =====
// Combinational conversion datapath between binary32 and binary16.
`default_nettype none
module fcv_core import fcv_pkg::*; (
  input  wire logic        mode_i,
  input  wire logic [31:0] operand_i,
  output logic [31:0]      result_o
);
  always_comb begin
    if (fcv_mode_e'(mode_i) == MODE_NARROW) begin
      result_o = {16'd0, fcv_narrow(operand_i)};
    end else begin
      result_o = fcv_widen(operand_i[15:0]);
    end
  end
endmodule
`default_nettype wire

// ===== src/fp32_fp16_converter.sv =====
// Top level of the binary32/binary16 converter.
// done_o rises once start has passed through in_vld_q and then out_vld_q.
// Throughput: one item per cycle; busy is never raised.
// The input register and result register bound the conversion logic.
// Reset clears the valid flags only; no result is shown after reset.
`default_nettype none
`include "fp32_fp16_converter_defines.svh"
module fp32_fp16_converter import fcv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode_i,
  input  wire logic [31:0] operand_i,
  output logic             done_o,
  output logic [31:0]      result_o
);
  logic        in_vld_q, out_vld_q;
  logic        mode_q;
  logic [31:0] op_q, res_d, res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_i;
    op_q   <= operand_i;
    res_q  <= res_d;
  end

  fcv_core u_core (
    .mode_i    (mode_q),
    .operand_i (op_q),
    .result_o  (res_d)
  );

  assign done_o   = out_vld_q;
  assign result_o = res_q;

  `FCV_ASSERT_NEXT(a_start_done, clk_i, rst_ni, start, in_vld_q ##1 done_o)
  `FCV_ASSERT_NEXT(a_narrow_hi, clk_i, rst_ni, in_vld_q && !mode_q, res_q[31:16] == 16'd0)
  `FCV_ASSERT_ALWAYS(a_no_busy, clk_i, rst_ni, !busy)
endmodule
`default_nettype wire

// ===== sim/fp32_fp16_converter_test.sv =====
// Testbench for the binary32/binary16 converter: directed and random items, scoreboard check.
`default_nettype none
module fp32_fp16_converter_test import fcv_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  class conv_scoreboard;
    logic [31:0] pending_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned unexpected;

    function logic [31:0] round_half_even(logic [31:0] sig, int unsigned sh);
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] half;
      q = sig >> sh;
      rem = sig & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 32'd1;
      return q;
    endfunction

    function logic [31:0] to_half(logic [31:0] w);
      logic [31:0] sgn;
      logic [31:0] ex;
      logic [31:0] man;
      logic [31:0] mag;
      logic [31:0] rem;
      sgn = {16'd0, w[31], 15'd0};
      ex = {24'd0, w[30:23]};
      man = {9'd0, w[22:0]};
      if (ex == 32'hFF) return sgn | ((man != 0) ? 32'h7E00 : 32'h7C00);
      if (ex >= 143) return sgn | 32'h7C00;
      if (ex == 0) return sgn;
      if (ex >= 113) begin
        mag = ((ex - 112) << 10) | (man >> 13);
        rem = man & 32'h1FFF;
        if (rem > 32'h1000 || (rem == 32'h1000 && mag[0])) mag = mag + 1;
        return sgn | mag;
      end
      if (126 - ex > 24) return sgn;
      return sgn | round_half_even(man | 32'h800000, 126 - ex);
    endfunction

    function logic [31:0] to_single(logic [15:0] h);
      logic [31:0] sgn;
      logic [31:0] man;
      int unsigned k;
      sgn = {h[15], 31'd0};
      man = {22'd0, h[9:0]};
      k = 0;
      if (h[14:10] == 5'h1F)
        return sgn | 32'h7F800000 | (man << 13) | ((man != 0) ? 32'h00400000 : 32'd0);
      if (h[14:10] == 5'd0) begin
        if (man == 0) return sgn;
        while (!man[10] && k < 10) begin
          man = man << 1;
          k++;
        end
        return sgn | ((113 - k) << 23) | ((man & 32'h3FF) << 13);
      end
      return sgn | (({27'd0, h[14:10]} + 112) << 23) | (man << 13);
    endfunction

    function void note_item(fcv_mode_e md, logic [31:0] op);
      pending_q.push_back(md == MODE_NARROW ? to_half(op) : to_single(op[15:0]));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_q.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %08h", got);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %08h, got %08h", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic mode_i;
  logic [31:0] operand_i;
  logic done_o;
  logic [31:0] result_o;
  conv_scoreboard board;
  int unsigned n_narrow;
  int unsigned n_widen;

  fp32_fp16_converter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .mode_i(mode_i), .operand_i(operand_i), .done_o(done_o), .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(result_o);
  end

  task automatic send_item(fcv_mode_e md, logic [31:0] op);
    start <= 1'b1;
    mode_i <= md;
    operand_i <= op;
    do @(posedge clk_i); while (busy);
    board.note_item(md, op);
    if (md == MODE_NARROW) n_narrow++; else n_widen++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int unsigned len;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_single();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'($urandom_range(100, 145));
      1: w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: w[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_half();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 3))
      0: w[14:10] = 5'd0;
      1: w[14:10] = 5'h1F;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] directed_narrow[$];
    logic [31:0] directed_widen[$];
    int unsigned wait_cycles;
    board = new();
    directed_narrow = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
      32'h7FC00001, 32'hFF800001, 32'h477FE000, 32'h477FF000, 32'h477FEFFF,
      32'h00000001, 32'h38800000, 32'h387FF000, 32'h33800000, 32'h33000000,
      32'h33000001, 32'h3F801000, 32'h3F803000, 32'hFFFFFFFF};
    directed_widen = '{32'h00000000, 32'hFFFF8000, 32'h00000001, 32'h000003FF,
      32'h00007C00, 32'h0000FC00, 32'h00007C01, 32'h00007E00, 32'h00007BFF,
      32'hFFFF3C00};
    start = 1'b0;
    mode_i = 1'b0;
    operand_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed_narrow[i]) send_item(MODE_NARROW, directed_narrow[i]);
    foreach (directed_widen[i]) send_item(MODE_WIDEN, directed_widen[i]);
    start <= 1'b0;
    wait_cycles = 0;
    while (board.pending_q.size() != 0 && wait_cycles < 1000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    for (int i = 0; i < 1300; i++) begin
      if (i < 200 || $urandom_range(0, 3) != 0)
        send_item(MODE_NARROW, $urandom_range(0, 1) ? rand_single() : $urandom());
      else
        send_item(MODE_WIDEN, rand_half());
      if (i >= 200 && i < 1100) idle_gap();
    end
    start <= 1'b0;
    wait_cycles = 0;
    while (board.pending_q.size() != 0 && wait_cycles < 1000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(negedge clk_i);
    $display("Converted %0d narrowing and %0d widening items, %0d results checked.",
             n_narrow, n_widen, board.checked);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
